// ===== hw/rtl/prts_pkg.sv =====
// Package for the priority round-robin task scheduler.
// Task state codes, request kinds and the controller state type.
// No dependencies.
package prts_pkg;

   localparam logic [2:0] ST_READY    = 3'd0;
   localparam logic [2:0] ST_RUNNING  = 3'd1;
   localparam logic [2:0] ST_BLOCKED  = 3'd2;
   localparam logic [2:0] ST_SLEEPING = 3'd3;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_SCHEDULE = 2'd1;
   localparam logic [1:0] KIND_REPORT   = 2'd2;
   localparam logic [1:0] KIND_LOAD     = 2'd3;

   localparam logic [1:0] REG_TASK_COUNT  = 2'd0;
   localparam logic [1:0] REG_WAKE_TASK   = 2'd1;
   localparam logic [1:0] REG_WAKE_PERIOD = 2'd2;
   localparam logic [1:0] REG_ISR_PERIOD  = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PREP,
      FSM_PASS_A,
      FSM_PASS_B
   } fsm_type;

endpackage

// ===== hw/rtl/priority_round_robin_task_scheduler.sv =====
// Top level of the priority round-robin task scheduler: APB registers,
// controller and the ring of prts_cell entries. Uses prts_pkg.
//
// The task table is a ring of MAX_TASKS cells that rotates one entry per
// cycle, while a pass runs, past a single head stage; a full turn brings it
// back in place. A tick, report or load takes one turn from start to result.
// A schedule first reduces last_chosen + 1 modulo the saturated task count
// by repeated subtraction, then takes one turn to find the best ready task
// and, when one is found, a second turn to mark it running. The result is a
// one-cycle strobe on rsp_valid; the receiver cannot stall it. busy is high
// while an item is in work.
module priority_round_robin_task_scheduler #(
   parameter int MAX_TASKS  = 16,
   parameter int SLEEP_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_task,
   input  logic [2:0]  req_new_state,
   input  logic [7:0]  req_priority,
   input  logic [15:0] req_sleep_ticks,
   output logic        rsp_valid,
   output logic        rsp_dispatch_valid,
   output logic [3:0]  rsp_dispatch_task,
   output logic [7:0]  rsp_dispatch_priority,
   output logic        rsp_timer_event,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int LAST_RST = (MAX_TASKS < 16 ? MAX_TASKS : 16) - 1;

   // ---------------- registers ----------------
   logic [4:0] tc_ff;
   logic [3:0] wt_ff;
   logic [7:0] wp_ff, ip_ff;
   logic       wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= 5'd16;
         wt_ff <= 4'd3;
         wp_ff <= 8'd4;
         ip_ff <= 8'd5;
      end else if (wr) begin
         unique case (paddr[3:2])
            prts_pkg::REG_TASK_COUNT:  tc_ff <= pwdata[4:0];
            prts_pkg::REG_WAKE_TASK:   wt_ff <= pwdata[3:0];
            prts_pkg::REG_WAKE_PERIOD: wp_ff <= pwdata[7:0];
            prts_pkg::REG_ISR_PERIOD:  ip_ff <= pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         prts_pkg::REG_TASK_COUNT:  prdata = {27'd0, tc_ff};
         prts_pkg::REG_WAKE_TASK:   prdata = {28'd0, wt_ff};
         prts_pkg::REG_WAKE_PERIOD: prdata = {24'd0, wp_ff};
         prts_pkg::REG_ISR_PERIOD:  prdata = {24'd0, ip_ff};
      endcase
   end

   // saturated active count
   logic [CW-1:0] cnt;
   always_comb begin
      priority if (tc_ff == 5'd0) cnt = CW'(1);
      else if (32'(tc_ff) > MAX_TASKS) cnt = CW'(MAX_TASKS);
      else cnt = CW'(tc_ff);
   end

   // ---------------- ring ----------------
   logic [2:0]            st_q   [MAX_TASKS];
   logic [7:0]            prio_q [MAX_TASKS];
   logic [SLEEP_BITS-1:0] sl_q   [MAX_TASKS];
   logic [2:0]            h_st;
   logic [7:0]            h_prio;
   logic [SLEEP_BITS-1:0] h_sl;
   logic                  shift;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      if (i == MAX_TASKS - 1) begin : g_tail
         prts_cell #(.SLEEP_BITS(SLEEP_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .st_in(h_st), .prio_in(h_prio), .sl_in(h_sl),
            .st_out(st_q[i]), .prio_out(prio_q[i]), .sl_out(sl_q[i]));
      end else begin : g_mid
         prts_cell #(.SLEEP_BITS(SLEEP_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .st_in(st_q[i+1]), .prio_in(prio_q[i+1]), .sl_in(sl_q[i+1]),
            .st_out(st_q[i]), .prio_out(prio_q[i]), .sl_out(sl_q[i]));
      end
   end

   // ---------------- controller ----------------
   prts_pkg::fsm_type     fsm_ff, fsm_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [CW-1:0]         r_ff, r_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [7:0]            wph_ff, wph_in, iph_ff, iph_in;
   logic                  wfire_ff, wfire_in, tev_ff, tev_in;
   logic [1:0]            kind_ff;
   logic [3:0]            task_ff;
   logic [2:0]            nst_ff;
   logic [7:0]            prq_ff;
   logic [SLEEP_BITS-1:0] slq_ff;
   logic                  any_ff, any_in, hiv_ff, hiv_in, lov_ff, lov_in;
   logic [IW-1:0]         hi_ff, hi_in, lo_ff, lo_in;
   logic [7:0]            best_ff, best_in;
   logic                  ov_ff, ov_in, odv_ff, odv_in, otev_ff, otev_in;
   logic [3:0]            otask_ff, otask_in;
   logic [7:0]            oprio_ff, oprio_in;

   logic          accept, last_step, active, at_req, ge_s;
   logic [IW-1:0] chosen;
   logic [31:0]   slx;
   logic [7:0]    wp, ip, wph_nx, iph_nx;

   assign accept    = start && !busy;
   assign busy      = fsm_ff != prts_pkg::FSM_IDLE;
   assign shift     = fsm_ff == prts_pkg::FSM_PASS_A || fsm_ff == prts_pkg::FSM_PASS_B;
   assign last_step = k_ff == IW'(MAX_TASKS - 1);
   assign active    = CW'(k_ff) < cnt;
   assign at_req    = 32'(k_ff) == 32'(task_ff);
   assign ge_s      = CW'(k_ff) >= r_ff;
   assign chosen    = hiv_ff ? hi_ff : lo_ff;
   assign slx       = {16'd0, req_sleep_ticks};
   assign wp        = (wp_ff == 8'd0) ? 8'd1 : wp_ff;
   assign ip        = (ip_ff == 8'd0) ? 8'd1 : ip_ff;
   assign wph_nx    = wph_ff + 8'd1;
   assign iph_nx    = iph_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= prts_pkg::FSM_IDLE;
         k_ff    <= '0;
         last_ff <= IW'(LAST_RST);
         wph_ff  <= '0;
         iph_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         fsm_ff  <= fsm_in;
         k_ff    <= k_in;
         last_ff <= last_in;
         wph_ff  <= wph_in;
         iph_ff  <= iph_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) kind_ff <= prts_pkg::KIND_TICK;
      else if (accept) kind_ff <= req_kind;
      if (accept) begin
         task_ff <= req_task;
         nst_ff  <= req_new_state;
         prq_ff  <= req_priority;
         slq_ff  <= slx[SLEEP_BITS-1:0];
      end
      r_ff     <= r_in;
      wfire_ff <= wfire_in;
      tev_ff   <= tev_in;
      any_ff   <= any_in;
      hiv_ff   <= hiv_in;
      lov_ff   <= lov_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      best_ff  <= best_in;
      odv_ff   <= odv_in;
      otev_ff  <= otev_in;
      otask_ff <= otask_in;
      oprio_ff <= oprio_in;
   end

   // head stage: entry leaving cell 0 is index k_ff
   always_comb begin
      h_st   = st_q[0];
      h_prio = prio_q[0];
      h_sl   = sl_q[0];
      if (fsm_ff == prts_pkg::FSM_PASS_B) begin
         if (k_ff == chosen) h_st = prts_pkg::ST_RUNNING;
      end else begin
         unique case (kind_ff)
            prts_pkg::KIND_TICK: begin
               if (active && st_q[0] == prts_pkg::ST_SLEEPING) begin
                  if (sl_q[0] <= SLEEP_BITS'(1)) begin
                     h_st = prts_pkg::ST_READY;
                     h_sl = '0;
                  end else begin
                     h_sl = sl_q[0] - SLEEP_BITS'(1);
                  end
               end
               // blocked tasks are not touched by the sleep update
               if (wfire_ff && 32'(k_ff) == 32'(wt_ff) && st_q[0] == prts_pkg::ST_BLOCKED)
                  h_st = prts_pkg::ST_READY;
            end
            prts_pkg::KIND_SCHEDULE: ;
            prts_pkg::KIND_REPORT: begin
               if (at_req) begin
                  h_st = (nst_ff == prts_pkg::ST_RUNNING) ? prts_pkg::ST_READY : nst_ff;
                  if (nst_ff == prts_pkg::ST_SLEEPING) h_sl = slq_ff;
               end
            end
            prts_pkg::KIND_LOAD: begin
               if (at_req) begin
                  h_st   = nst_ff;
                  h_prio = prq_ff;
                  h_sl   = slq_ff;
               end
            end
         endcase
      end
   end

   always_comb begin
      fsm_in   = fsm_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      last_in  = last_ff;
      wph_in   = wph_ff;
      iph_in   = iph_ff;
      wfire_in = wfire_ff;
      tev_in   = tev_ff;
      any_in   = any_ff;
      hiv_in   = hiv_ff;
      lov_in   = lov_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      best_in  = best_ff;
      ov_in    = 1'b0;
      odv_in   = 1'b0;
      otev_in  = 1'b0;
      otask_in = '0;
      oprio_in = '0;
      unique case (fsm_ff)
         prts_pkg::FSM_IDLE: begin
            k_in   = '0;
            any_in = 1'b0;
            hiv_in = 1'b0;
            lov_in = 1'b0;
            r_in   = CW'(last_ff) + CW'(1);
            wfire_in = 1'b0;
            tev_in   = 1'b0;
            if (accept) begin
               if (req_kind == prts_pkg::KIND_TICK) begin
                  if (wph_nx >= wp) begin
                     wph_in   = '0;
                     wfire_in = (32'(wt_ff) < MAX_TASKS);
                  end else begin
                     wph_in = wph_nx;
                  end
                  if (iph_nx >= ip) begin
                     iph_in = '0;
                     tev_in = 1'b1;
                  end else begin
                     iph_in = iph_nx;
                  end
               end
               fsm_in = (req_kind == prts_pkg::KIND_SCHEDULE) ? prts_pkg::FSM_PREP
                                                              : prts_pkg::FSM_PASS_A;
            end
         end
         prts_pkg::FSM_PREP: begin
            // start index = (last_chosen + 1) mod count, one subtract a cycle
            if (r_ff >= cnt) r_in = r_ff - cnt;
            else fsm_in = prts_pkg::FSM_PASS_A;
         end
         prts_pkg::FSM_PASS_A: begin
            k_in = k_ff + IW'(1);
            if (kind_ff == prts_pkg::KIND_SCHEDULE && active &&
                st_q[0] == prts_pkg::ST_READY) begin
               if (!any_ff || prio_q[0] > best_ff) begin
                  any_in  = 1'b1;
                  best_in = prio_q[0];
                  hiv_in  = ge_s;
                  lov_in  = !ge_s;
                  hi_in   = k_ff;
                  lo_in   = k_ff;
               end else if (prio_q[0] == best_ff) begin
                  if (ge_s && !hiv_ff) begin
                     hiv_in = 1'b1;
                     hi_in  = k_ff;
                  end
                  if (!ge_s && !lov_ff) begin
                     lov_in = 1'b1;
                     lo_in  = k_ff;
                  end
               end
            end
            if (last_step) begin
               // ring is back in place: index count restarts for the next turn
               k_in = '0;
               if (kind_ff == prts_pkg::KIND_SCHEDULE && any_in) begin
                  fsm_in = prts_pkg::FSM_PASS_B;
               end else begin
                  fsm_in  = prts_pkg::FSM_IDLE;
                  ov_in   = 1'b1;
                  otev_in = (kind_ff == prts_pkg::KIND_TICK) && tev_ff;
               end
            end
         end
         prts_pkg::FSM_PASS_B: begin
            k_in = k_ff + IW'(1);
            if (last_step) begin
               fsm_in   = prts_pkg::FSM_IDLE;
               last_in  = chosen;
               ov_in    = 1'b1;
               odv_in   = 1'b1;
               otask_in = 4'(32'(chosen));
               oprio_in = best_ff;
            end
         end
      endcase
   end

   assign rsp_valid             = ov_ff;
   assign rsp_dispatch_valid    = ov_ff && odv_ff;
   assign rsp_dispatch_task     = ov_ff ? otask_ff : 4'd0;
   assign rsp_dispatch_priority = ov_ff ? oprio_ff : 8'd0;
   assign rsp_timer_event       = ov_ff && otev_ff;

endmodule

// ===== hw/rtl/prts_cell.sv =====
// One task table entry of the scheduler ring: state, priority, sleep count.
// Shifts its entry on to the neighbour when shift is high. Uses prts_pkg.
module prts_cell #(
   parameter int SLEEP_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic [2:0]            st_in,
   input  logic [7:0]            prio_in,
   input  logic [SLEEP_BITS-1:0] sl_in,
   output logic [2:0]            st_out,
   output logic [7:0]            prio_out,
   output logic [SLEEP_BITS-1:0] sl_out
);

   logic [2:0]            st_ff;
   logic [7:0]            prio_ff;
   logic [SLEEP_BITS-1:0] sl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= prts_pkg::ST_BLOCKED;
         prio_ff <= '0;
         sl_ff   <= '0;
      end else if (shift) begin
         st_ff   <= st_in;
         prio_ff <= prio_in;
         sl_ff   <= sl_in;
      end
   end

   assign st_out   = st_ff;
   assign prio_out = prio_ff;
   assign sl_out   = sl_ff;

endmodule

// ===== hw/rtl/prts_checker.sv =====
// Port-level checks for the priority round-robin task scheduler,
// bound to the top level. Depends on priority_round_robin_task_scheduler.
module prts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_dispatch_valid,
   input logic rsp_timer_event
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted request");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_flags_in_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_dispatch_valid || rsp_timer_event) |->
         rsp_valid && !(rsp_dispatch_valid && rsp_timer_event))
      else $error("result flag outside a result or both flags set");

endmodule

bind priority_round_robin_task_scheduler prts_checker u_prts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_dispatch_valid(rsp_dispatch_valid),
   .rsp_timer_event(rsp_timer_event)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the priority round-robin task scheduler.
// Drives requests and APB register writes, predicts each result in step and
// compares it on the strobe. Depends on prts_pkg and the scheduler top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTASK = 16;
   localparam int LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [3:0]  req_task;
   logic [2:0]  req_new_state;
   logic [7:0]  req_priority;
   logic [15:0] req_sleep_ticks;
   logic        rsp_valid;
   logic        rsp_dispatch_valid;
   logic [3:0]  rsp_dispatch_task;
   logic [7:0]  rsp_dispatch_priority;
   logic        rsp_timer_event;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   typedef struct packed {
      logic       dvalid;
      logic [3:0] dtask;
      logic [7:0] dprio;
      logic       tevent;
   } outcome_type;

   // shadow copy of the scheduler
   logic [4:0]  sh_count;
   logic [3:0]  sh_wake_task;
   logic [7:0]  sh_wake_period;
   logic [7:0]  sh_isr_period;
   logic [2:0]  sh_state [NTASK];
   logic [7:0]  sh_prio [NTASK];
   logic [15:0] sh_sleep [NTASK];
   logic [3:0]  sh_last;
   logic [7:0]  sh_wake_phase;
   logic [7:0]  sh_isr_phase;

   outcome_type pending_outcomes[$];
   int       fails;
   int       cycles;
   bit       idle_on;
   logic [3:0] last_dispatched;

   priority_round_robin_task_scheduler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_task(req_task), .req_new_state(req_new_state),
      .req_priority(req_priority), .req_sleep_ticks(req_sleep_ticks),
      .rsp_valid(rsp_valid), .rsp_dispatch_valid(rsp_dispatch_valid),
      .rsp_dispatch_task(rsp_dispatch_task),
      .rsp_dispatch_priority(rsp_dispatch_priority),
      .rsp_timer_event(rsp_timer_event),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int live_count();
      if (sh_count == 0) return 1;
      if (sh_count > NTASK) return NTASK;
      return int'(sh_count);
   endfunction

   function automatic bit phase_advance(ref logic [7:0] phase, input logic [7:0] period);
      logic [7:0] p;
      p = (period == 0) ? 8'd1 : period;
      phase = phase + 8'd1;
      if (phase >= p) begin
         phase = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_outcome(input logic [1:0] kind, input logic [3:0] tsk,
                                  input logic [2:0] nst, input logic [7:0] prio,
                                  input logic [15:0] sl);
      outcome_type o;
      int n;
      int idx;
      bit any;
      logic [7:0] best;
      o = '0;
      n = live_count();
      any = 1'b0;
      best = 8'd0;
      case (kind)
         prts_pkg::KIND_TICK: begin
            for (int i = 0; i < n; i++)
               if (sh_state[i] == prts_pkg::ST_SLEEPING) begin
                  if (sh_sleep[i] <= 1) begin
                     sh_sleep[i] = 16'd0;
                     sh_state[i] = prts_pkg::ST_READY;
                  end else sh_sleep[i] = sh_sleep[i] - 16'd1;
               end
            if (phase_advance(sh_wake_phase, sh_wake_period) &&
                sh_state[sh_wake_task] == prts_pkg::ST_BLOCKED)
               sh_state[sh_wake_task] = prts_pkg::ST_READY;
            o.tevent = phase_advance(sh_isr_phase, sh_isr_period);
         end
         prts_pkg::KIND_SCHEDULE: begin
            for (int i = 0; i < n; i++)
               if (sh_state[i] == prts_pkg::ST_READY && (!any || sh_prio[i] > best)) begin
                  best = sh_prio[i];
                  any = 1'b1;
               end
            if (any)
               for (int i = 1; i <= n; i++) begin
                  idx = (int'(sh_last) + i) % n;
                  if (sh_state[idx] == prts_pkg::ST_READY && sh_prio[idx] == best) begin
                     sh_last = idx[3:0];
                     sh_state[idx] = prts_pkg::ST_RUNNING;
                     o.dvalid = 1'b1;
                     o.dtask = idx[3:0];
                     o.dprio = best;
                     last_dispatched = idx[3:0];
                     break;
                  end
               end
         end
         prts_pkg::KIND_REPORT: begin
            if (nst == prts_pkg::ST_RUNNING) sh_state[tsk] = prts_pkg::ST_READY;
            else begin
               sh_state[tsk] = nst;
               if (nst == prts_pkg::ST_SLEEPING) sh_sleep[tsk] = sl;
            end
         end
         default: begin
            sh_state[tsk] = nst;
            sh_prio[tsk] = prio;
            sh_sleep[tsk] = sl;
         end
      endcase
      pending_outcomes.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with no request outstanding");
            fails++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_dispatch_valid !== want.dvalid) begin
               $error("dispatch_valid expected %0d got %0d", want.dvalid, rsp_dispatch_valid);
               fails++;
            end
            if (rsp_dispatch_task !== want.dtask) begin
               $error("dispatch_task expected %0d got %0d", want.dtask, rsp_dispatch_task);
               fails++;
            end
            if (rsp_dispatch_priority !== want.dprio) begin
               $error("dispatch_priority expected %0d got %0d", want.dprio,
                      rsp_dispatch_priority);
               fails++;
            end
            if (rsp_timer_event !== want.tevent) begin
               $error("timer_event expected %0d got %0d", want.tevent, rsp_timer_event);
               fails++;
            end
         end
      end
   end

   // start is left high; the gap task lowers it only when a gap follows
   task automatic send_request(input logic [1:0] kind, input logic [3:0] tsk,
                               input logic [2:0] nst, input logic [7:0] prio,
                               input logic [15:0] sl);
      start <= 1'b1;
      req_kind <= kind;
      req_task <= tsk;
      req_new_state <= nst;
      req_priority <= prio;
      req_sleep_ticks <= sl;
      do @(posedge clock); while (busy);
      predict_outcome(kind, tsk, nst, prio, sl);
   endtask

   task automatic idle_gap();
      int g;
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) g = 0;
      else if (r < 93) g = $urandom_range(1, 4);
      else g = $urandom_range(20, 70);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] regno, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {regno, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (regno)
         prts_pkg::REG_TASK_COUNT:  sh_count = value[4:0];
         prts_pkg::REG_WAKE_TASK:   sh_wake_task = value[3:0];
         prts_pkg::REG_WAKE_PERIOD: sh_wake_period = value[7:0];
         default:                   sh_isr_period = value[7:0];
      endcase
   endtask

   task automatic configure(input logic [4:0] cnt, input logic [3:0] wt,
                            input logic [7:0] wp, input logic [7:0] ip);
      drain();
      csr_write(prts_pkg::REG_TASK_COUNT, {27'd0, cnt});
      csr_write(prts_pkg::REG_WAKE_TASK, {28'd0, wt});
      csr_write(prts_pkg::REG_WAKE_PERIOD, {24'd0, wp});
      csr_write(prts_pkg::REG_ISR_PERIOD, {24'd0, ip});
   endtask

   task automatic test_directed();
      idle_on = 1'b0;
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);    // nothing ready
      send_request(prts_pkg::KIND_LOAD, 4'd0, prts_pkg::ST_READY, 8'd255, 16'hFFFF);
      send_request(prts_pkg::KIND_LOAD, 4'd15, prts_pkg::ST_READY, 8'd255, 16'd0);
      send_request(prts_pkg::KIND_LOAD, 4'd7, prts_pkg::ST_READY, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_LOAD, 4'd5, prts_pkg::ST_SLEEPING, 8'd200, 16'd2);
      send_request(prts_pkg::KIND_LOAD, 4'd6, prts_pkg::ST_SLEEPING, 8'd200, 16'd0);
      send_request(prts_pkg::KIND_LOAD, 4'd8, 3'd5, 8'd255, 16'd0);       // inert codes
      send_request(prts_pkg::KIND_LOAD, 4'd9, 3'd7, 8'd255, 16'd0);
      send_request(prts_pkg::KIND_LOAD, 4'd10, 3'd4, 8'd255, 16'd0);
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_REPORT, 4'd0, prts_pkg::ST_RUNNING, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_REPORT, 4'd15, prts_pkg::ST_SLEEPING, 8'd0, 16'd1);
      send_request(prts_pkg::KIND_REPORT, 4'd7, 3'd6, 8'd0, 16'd0);
      for (int i = 0; i < 6; i++)
         send_request(prts_pkg::KIND_TICK, 4'd0, 3'd0, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_REPORT, 4'd3, prts_pkg::ST_BLOCKED, 8'd0, 16'd0);
      send_request(prts_pkg::KIND_SCHEDULE, 4'd0, 3'd0, 8'd0, 16'd0);
   endtask

   task automatic test_random(input int count);
      int r;
      logic [2:0] nst;
      for (int i = 0; i < count; i++) begin
         idle_gap();
         r = $urandom_range(0, 99);
         nst = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, 3));
         if (r < 20)
            send_request(prts_pkg::KIND_LOAD, 4'($urandom), nst,
                         8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                         16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4)));
         else if (r < 50)
            send_request(prts_pkg::KIND_SCHEDULE, 4'($urandom), 3'($urandom), 8'($urandom),
                         16'($urandom));
         else if (r < 75)
            send_request(prts_pkg::KIND_REPORT, $urandom_range(0, 3) == 0 ? 4'($urandom) :
                         last_dispatched, nst, 8'($urandom),
                         16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4)));
         else
            send_request(prts_pkg::KIND_TICK, 4'($urandom), 3'($urandom), 8'($urandom),
                         16'($urandom));
      end
   endtask

   task automatic test_register_settings();
      configure(5'd1, 4'd0, 8'd1, 8'd1);
      test_random(100);
      configure(5'd4, 4'd10, 8'd0, 8'd0);    // wake task outside active part
      test_random(150);
      configure(5'd0, 4'd15, 8'd255, 8'd255);
      test_random(100);
      configure(5'd31, 4'd2, 8'd3, 8'd2);    // count above table size
      test_random(150);
      configure(5'd9, 4'd5, 8'd2, 8'd7);
      test_random(150);
      configure(5'd16, 4'd15, 8'd1, 8'd1);   // periods below the running phase
      test_random(80);
   endtask

   initial begin
      fails = 0;
      cycles = 0;
      idle_on = 1'b0;
      last_dispatched = 4'd0;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= prts_pkg::KIND_TICK;
      req_task <= 4'd0;
      req_new_state <= 3'd0;
      req_priority <= 8'd0;
      req_sleep_ticks <= 16'd0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= 4'd0;
      pwdata <= 32'd0;
      sh_count = 5'd16;
      sh_wake_task = 4'd3;
      sh_wake_period = 8'd4;
      sh_isr_period = 8'd5;
      for (int i = 0; i < NTASK; i++) begin
         sh_state[i] = prts_pkg::ST_BLOCKED;
         sh_prio[i] = 8'd0;
         sh_sleep[i] = 16'd0;
      end
      sh_last = 4'd15;
      sh_wake_phase = 8'd0;
      sh_isr_phase = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_on = 1'b1;
      test_random(200);
      test_register_settings();
      drain();
      if (fails == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
